/* rtl/text_console_char_engine_unit_defines.svh */
// Assertion macros for the text console engine.
// No dependencies; included by the top level only.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication
`define TCCE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TCCE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tcce_pkg.sv */
// Shared types and constants of the text console engine.
// No dependencies; used by all RTL modules.
package tcce_pkg;

    // Opcodes of an input transaction
    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_PLACE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] REG_LINE_COUNT   = 2'd1;
    localparam logic [1:0] REG_FOREGROUND   = 2'd2;
    localparam logic [1:0] REG_BACKGROUND   = 2'd3;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;

    // Command kinds after classification
    localparam logic [3:0] K_PRINT = 4'd0;
    localparam logic [3:0] K_BS    = 4'd1;
    localparam logic [3:0] K_TAB   = 4'd2;
    localparam logic [3:0] K_LF    = 4'd3;
    localparam logic [3:0] K_FF    = 4'd4;
    localparam logic [3:0] K_CR    = 4'd5;
    localparam logic [3:0] K_OTHER = 4'd6;
    localparam logic [3:0] K_PLACE = 4'd7;
    localparam logic [3:0] K_READ  = 4'd8;
    localparam logic [3:0] K_NOP   = 4'd9;

    // Width of a linear cell position (31 * 127 + 127 fits)
    localparam int LIN_W = 12;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] character;
        logic [4:0] line;
        logic [6:0] column;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  cursor_line;
        logic [6:0]  cursor_column;
        logic [10:0] cursor_linear;
        logic [15:0] cell_data;
        logic        cell_valid;
    } out_item_t;

    // Effective configuration (counts already forced into range)
    typedef struct packed {
        logic [6:0] cc;
        logic [4:0] lc;
        logic [3:0] fg;
        logic [3:0] bg;
    } cfg_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] character;
        logic [4:0] line;
        logic [6:0] column;
    } cmd_t;

    // Queue head toward the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_link_t;

    // Back end status toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

endpackage

/* rtl/text_console_char_engine_unit.sv */
// Top level of the text console engine: configuration registers, front and back ends.
// Depends on tcce_pkg, tcce_front, tcce_back and the assertion macro header.
//
//  Channel   Ports                            Transfers
//  input     s_valid / s_ready / s_data       one command per transaction
//  result    m_valid / m_ready / m_data       one result per command
//  config    cfg_wr_en / cfg_index / cfg_wdata  register write, no wait
//
// Cursor place, no-op and plain control bytes pass through decode and report in the back
// end; a cell write or cell read passes decode, address multiply, memory access, report.
// Scroll walks lines * columns cells at one cell per cycle through the memory's read and
// write ports; form feed clears all CELL_DEPTH cells at one per cycle.
// After reset a clearing pass over all CELL_DEPTH cells runs with s_ready low.
// A two-entry queue and the output register let either side stall on its own.
`include "text_console_char_engine_unit_defines.svh"
module text_console_char_engine_unit #(
    parameter int CELL_DEPTH = 2048,
    parameter int MAX_LINES  = 32,
    parameter int TAB_STOP   = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcce_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcce_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_wdata
);
    import tcce_pkg::*;

    logic [6:0] col_count_reg;
    logic [4:0] line_count_reg;
    logic [3:0] fg_reg, bg_reg;
    logic [4:0] lc_min;
    cfg_t       cfg;
    q_link_t    qlink;
    back_stat_t bstat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg  <= 7'd80;
            line_count_reg <= 5'd25;
            fg_reg         <= 4'd15;
            bg_reg         <= 4'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLUMN_COUNT: col_count_reg  <= cfg_wdata;
                REG_LINE_COUNT:   line_count_reg <= cfg_wdata[4:0];
                REG_FOREGROUND:   fg_reg         <= cfg_wdata[3:0];
                REG_BACKGROUND:   bg_reg         <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Effective counts: zero acts as one, lines capped at MAX_LINES
    assign lc_min = (line_count_reg == 5'd0) ? 5'd1 : line_count_reg;
    assign cfg.cc = (col_count_reg == 7'd0) ? 7'd1 : col_count_reg;
    assign cfg.lc = (int'(lc_min) > MAX_LINES) ? 5'(MAX_LINES) : lc_min;
    assign cfg.fg = fg_reg;
    assign cfg.bg = bg_reg;

    tcce_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .bstat   (bstat),
        .qlink   (qlink)
    );

    tcce_back #(
        .CELL_DEPTH (CELL_DEPTH),
        .MAX_LINES  (MAX_LINES),
        .TAB_STOP   (TAB_STOP)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .qlink   (qlink),
        .bstat   (bstat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Checks
    `TCCE_ASSERT_IMP(a_pop_needs_item, aclk, aresetn, bstat.pop, qlink.valid, "pop from empty queue")
    `TCCE_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, bstat.clearing, !s_ready, "accept during clear")
    `TCCE_ASSERT_IMP(a_cell_zero, aclk, aresetn, m_valid && !m_data.cell_valid, m_data.cell_data == 16'd0, "stray cell data")
    `TCCE_ASSERT_NXT(a_pop_no_clear, aclk, aresetn, bstat.pop, !bstat.clearing, "pop led to clear")

endmodule

/* rtl/tcce_front.sv */
// Front end: accepts input transactions, classifies them, holds a two-entry queue.
// Depends on tcce_pkg.
module tcce_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tcce_pkg::in_item_t   s_data,
    input  tcce_pkg::back_stat_t bstat,
    output tcce_pkg::q_link_t    qlink
);
    import tcce_pkg::*;

    cmd_t       q_mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;
    cmd_t       cls;

    // Classify the incoming transaction
    always_comb begin
        cls.character = s_data.character;
        cls.line      = s_data.line;
        cls.column    = s_data.column;
        case (s_data.opcode)
            OP_CHAR: begin
                if (s_data.character >= CH_SPACE && s_data.character <= CH_TILDE) begin
                    cls.kind = K_PRINT;
                end else begin
                    case (s_data.character)
                        CH_BS:   cls.kind = K_BS;
                        CH_TAB:  cls.kind = K_TAB;
                        CH_LF:   cls.kind = K_LF;
                        CH_FF:   cls.kind = K_FF;
                        CH_CR:   cls.kind = K_CR;
                        default: cls.kind = K_OTHER;
                    endcase
                end
            end
            OP_PLACE: cls.kind = K_PLACE;
            OP_READ:  cls.kind = K_READ;
            default:  cls.kind = K_NOP;
        endcase
    end

    assign s_ready    = (count_reg != 2'd2) && !bstat.clearing;
    assign push       = s_valid && s_ready;
    assign qlink.valid = (count_reg != 2'd0);
    assign qlink.cmd   = q_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !bstat.pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && bstat.pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue storage and pointers
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (bstat.pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

/* rtl/tcce_back.sv */
// Back end: executes commands on the cursor, line table and cell memory.
// Depends on tcce_pkg.
module tcce_back #(
    parameter int CELL_DEPTH = 2048,
    parameter int MAX_LINES  = 32,
    parameter int TAB_STOP   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcce_pkg::cfg_t       cfg,
    input  tcce_pkg::q_link_t    qlink,
    output tcce_pkg::back_stat_t bstat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tcce_pkg::out_item_t  m_data
);
    import tcce_pkg::*;

    localparam int ADDR_W = $clog2(CELL_DEPTH);
    localparam int IW     = (ADDR_W + 1 > 13) ? ADDR_W + 1 : 13;
    localparam int LW     = $clog2(MAX_LINES);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_SCLIM  = 4'd3;
    localparam logic [3:0] S_SCROLL = 4'd4;
    localparam logic [3:0] S_ADDR   = 4'd5;
    localparam logic [3:0] S_WRITE  = 4'd6;
    localparam logic [3:0] S_RD     = 4'd7;
    localparam logic [3:0] S_LIN    = 4'd8;

    // Tab advance per column
    typedef logic [4:0] tab_tbl_t [128];
    function automatic tab_tbl_t build_tab();
        tab_tbl_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = 5'(TAB_STOP - (i % TAB_STOP));
        end
        return t;
    endfunction
    localparam tab_tbl_t TAB_ADV = build_tab();

    logic [3:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [4:0]        cur_row_reg, cur_row_next, mark_row_reg, mark_row_next;
    logic [6:0]        cur_col_reg, cur_col_next, mark_col_reg, mark_col_next;
    logic [7:0]        last_reg [MAX_LINES];
    logic [7:0]        last_next [MAX_LINES];
    logic [4:0]        tgt_row_reg, tgt_row_next;
    logic [6:0]        tgt_col_reg, tgt_col_next;
    logic              wr_en_reg, wr_en_next, rd_en_reg, rd_en_next;
    logic [15:0]       wr_data_reg, wr_data_next;
    logic [IW-1:0]     addr_reg, addr_next, copy_end_reg, copy_end_next;
    logic [IW-1:0]     idx_reg, idx_next, p_idx_reg, p_idx_next;
    logic              p_valid_reg, p_valid_next, p_blank_reg, p_blank_next;
    logic              p_srcok_reg, p_srcok_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              clr_lin_reg, clr_lin_next;
    logic              cvalid_reg, cvalid_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [15:0]       mem [CELL_DEPTH];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    logic [4:0]        mrow;
    logic [6:0]        mcol;
    logic [LIN_W-1:0]  lin;
    logic [6:0]        ccm1;
    logic [IW-1:0]     src, total;
    logic              out_free;
    logic [15:0]       blank;

    assign ccm1     = cfg.cc - 7'd1;
    assign out_free = !m_valid_reg || m_ready;
    assign blank    = {cfg.bg, cfg.fg, CH_SPACE};
    assign src      = idx_reg + IW'(cfg.cc);
    assign total    = copy_end_reg + IW'(cfg.cc);

    // Shared multiplier: column + line * column count
    always_comb begin
        case (state_reg)
            S_ADDR: begin
                mrow = tgt_row_reg;
                mcol = tgt_col_reg;
            end
            S_SCLIM: begin
                mrow = cfg.lc - 5'd1;
                mcol = 7'd0;
            end
            default: begin
                mrow = cur_row_reg;
                mcol = cur_col_reg;
            end
        endcase
        lin = LIN_W'(mcol) + LIN_W'(mrow) * LIN_W'(cfg.cc);
    end

    // Sequencer
    always_comb begin
        logic [4:0] r, pr, w_row;
        logic [6:0] c, tc, w_col;
        logic [7:0] lv, tsum, ttgt, w_ch, lw_val;
        logic [4:0] lw_row;
        logic       lw_en, do_scroll, do_clear, w_en, step, prev_path;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        mark_row_next = mark_row_reg;
        mark_col_next = mark_col_reg;
        last_next     = last_reg;
        tgt_row_next  = tgt_row_reg;
        tgt_col_next  = tgt_col_reg;
        wr_en_next    = wr_en_reg;
        rd_en_next    = rd_en_reg;
        wr_data_next  = wr_data_reg;
        addr_next     = addr_reg;
        copy_end_next = copy_end_reg;
        idx_next      = idx_reg;
        p_idx_next    = p_idx_reg;
        p_valid_next  = 1'b0;
        p_blank_next  = p_blank_reg;
        p_srcok_next  = p_srcok_reg;
        clr_next      = clr_reg;
        clr_lin_next  = clr_lin_reg;
        cvalid_next   = cvalid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg[ADDR_W-1:0];
        mem_wdata     = wr_data_reg;
        mem_raddr     = addr_reg[ADDR_W-1:0];
        bstat.pop     = 1'b0;

        r = cur_row_reg;
        c = cur_col_reg;
        pr = 5'd0;
        tc = 7'd0;
        lv = 8'd0;
        tsum = 8'd0;
        ttgt = 8'd0;
        w_row = 5'd0;
        w_col = 7'd0;
        w_ch = CH_SPACE;
        lw_en = 1'b0;
        lw_row = 5'd0;
        lw_val = 8'd0;
        do_scroll = 1'b0;
        do_clear = 1'b0;
        w_en = 1'b0;
        step = 1'b0;
        prev_path = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 16'd0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(CELL_DEPTH - 1)) begin
                    clr_next   = '0;
                    state_next = clr_lin_reg ? S_LIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (qlink.valid) begin
                    bstat.pop  = 1'b1;
                    cmd_next   = qlink.cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (cmd_reg.kind)
                    K_PRINT: begin
                        if (c > ccm1 && (6'(r) + 6'd1 <= 6'(cfg.lc))) begin
                            r = r + 5'd1;
                            c = 7'd0;
                        end
                        if (r >= cfg.lc) begin
                            do_scroll = 1'b1;
                            r = cfg.lc - 5'd1;
                            c = 7'd0;
                        end else begin
                            lw_en  = 1'b1;
                            lw_row = r;
                            lw_val = 8'(c);
                        end
                        w_en  = 1'b1;
                        w_row = r;
                        w_col = c;
                        w_ch  = cmd_reg.character;
                        c = c + 7'd1;
                    end
                    K_BS: begin
                        if (mark_row_reg == r) begin
                            step = (c > mark_col_reg);
                        end else if (mark_row_reg < r) begin
                            step      = (c != 7'd0);
                            prev_path = (c == 7'd0);
                        end
                        if (step) begin
                            tc = c - 7'd1;
                            if (r <= cfg.lc && tc <= cfg.cc) begin
                                c = tc;
                            end
                            lw_en  = 1'b1;
                            lw_row = r;
                            lw_val = 8'(c);
                            w_en   = 1'b1;
                        end
                        if (prev_path) begin
                            pr = r - 5'd1;
                            lv = (pr < cfg.lc) ? last_reg[LW'(pr)] : 8'd0;
                            if (lv >= 8'(cfg.cc)) begin
                                lw_en  = 1'b1;
                                lw_row = pr;
                                lw_val = 8'(ccm1);
                                lv     = 8'(ccm1);
                            end
                            if (pr <= cfg.lc && lv <= 8'(cfg.cc)) begin
                                r = pr;
                                c = lv[6:0];
                            end
                            w_en = 1'b1;
                        end
                        w_row = r;
                        w_col = c;
                    end
                    K_TAB: begin
                        tsum = 8'(c) + 8'(TAB_STOP);
                        if (tsum < 8'(ccm1)) begin
                            ttgt = 8'(c) + 8'(TAB_ADV[c]);
                        end else begin
                            ttgt = 8'(ccm1);
                        end
                        if (r <= cfg.lc && ttgt <= 8'(cfg.cc)) begin
                            c = ttgt[6:0];
                        end
                        lw_en  = 1'b1;
                        lw_row = r;
                        lw_val = 8'(c);
                    end
                    K_LF: begin
                        if (6'(r) < 6'(cfg.lc) - 6'd1) begin
                            r = r + 5'd1;
                            c = 7'd0;
                            lw_en  = 1'b1;
                            lw_row = r;
                            lw_val = 8'd0;
                        end else begin
                            do_scroll = 1'b1;
                            r = cfg.lc - 5'd1;
                            c = 7'd0;
                        end
                    end
                    K_FF: begin
                        do_clear = 1'b1;
                    end
                    K_CR: begin
                        if (r <= cfg.lc) begin
                            c = 7'd0;
                        end
                        lw_en  = 1'b1;
                        lw_row = r;
                        lw_val = 8'(c);
                    end
                    K_PLACE: begin
                        if (cmd_reg.line < cfg.lc && cmd_reg.column < cfg.cc) begin
                            r = cmd_reg.line;
                            c = cmd_reg.column;
                        end
                    end
                    default: begin
                    end
                endcase

                cur_row_next = r;
                cur_col_next = c;
                if (cmd_reg.kind != K_PLACE && cmd_reg.kind != K_READ &&
                    cmd_reg.kind != K_NOP) begin
                    mark_row_next = r;
                    mark_col_next = c;
                end

                // Line table update: scroll shift or one entry
                if (do_scroll) begin
                    for (int i = 0; i < MAX_LINES; i++) begin
                        if (i + 1 < int'(cfg.lc)) begin
                            last_next[i] = last_reg[(i + 1) % MAX_LINES];
                        end else if (i + 1 == int'(cfg.lc)) begin
                            last_next[i] = 8'd0;
                        end
                    end
                end else if (lw_en && lw_row < cfg.lc) begin
                    last_next[LW'(lw_row)] = lw_val;
                end

                // Memory work plan
                rd_en_next   = (cmd_reg.kind == K_READ) &&
                               cmd_reg.line < cfg.lc && cmd_reg.column < cfg.cc;
                wr_en_next   = w_en && w_row < cfg.lc && w_col < cfg.cc;
                tgt_row_next = (cmd_reg.kind == K_READ) ? cmd_reg.line : w_row;
                tgt_col_next = (cmd_reg.kind == K_READ) ? cmd_reg.column : w_col;
                wr_data_next = {cfg.bg, cfg.fg, w_ch};
                cvalid_next  = 1'b0;

                if (do_clear) begin
                    clr_next     = '0;
                    clr_lin_next = 1'b1;
                    state_next   = S_CLEAR;
                end else if (do_scroll) begin
                    state_next = S_SCLIM;
                end else if (wr_en_next || rd_en_next) begin
                    state_next = S_ADDR;
                end else begin
                    state_next = S_LIN;
                end
            end
            S_SCLIM: begin
                copy_end_next = IW'(lin);
                idx_next      = '0;
                state_next    = S_SCROLL;
            end
            S_SCROLL: begin
                // Read stage: fetch the cell one line below
                mem_raddr = src[ADDR_W-1:0];
                if (idx_reg < total) begin
                    p_valid_next = 1'b1;
                    p_idx_next   = idx_reg;
                    p_blank_next = (idx_reg >= copy_end_reg);
                    p_srcok_next = (src < IW'(CELL_DEPTH));
                    idx_next     = idx_reg + IW'(1);
                end else if (!p_valid_reg) begin
                    state_next = wr_en_reg ? S_ADDR : S_LIN;
                end
                // Write stage
                if (p_valid_reg && p_idx_reg < IW'(CELL_DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = p_idx_reg[ADDR_W-1:0];
                    mem_wdata = p_blank_reg ? blank : (p_srcok_reg ? rdata_reg : 16'd0);
                end
            end
            S_ADDR: begin
                addr_next  = IW'(lin);
                state_next = wr_en_reg ? S_WRITE : S_RD;
            end
            S_WRITE: begin
                mem_we     = (addr_reg < IW'(CELL_DEPTH));
                state_next = S_LIN;
            end
            S_RD: begin
                cvalid_next = rd_en_reg && (addr_reg < IW'(CELL_DEPTH));
                state_next  = S_LIN;
            end
            S_LIN: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.cursor_line   = cur_row_reg;
                    m_data_next.cursor_column = cur_col_reg;
                    m_data_next.cursor_linear = lin[10:0];
                    m_data_next.cell_data     = cvalid_reg ? rdata_reg : 16'd0;
                    m_data_next.cell_valid    = cvalid_reg;
                    clr_lin_next              = 1'b0;
                    if (qlink.valid) begin
                        bstat.pop  = 1'b1;
                        cmd_next   = qlink.cmd;
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign bstat.clearing = (state_reg == S_CLEAR);
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

    // Cell memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        tgt_row_reg  <= tgt_row_next;
        tgt_col_reg  <= tgt_col_next;
        wr_data_reg  <= wr_data_next;
        addr_reg     <= addr_next;
        copy_end_reg <= copy_end_next;
        p_idx_reg    <= p_idx_next;
        p_blank_reg  <= p_blank_next;
        p_srcok_reg  <= p_srcok_next;
        m_data_reg   <= m_data_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cur_row_reg  <= 5'd0;
            cur_col_reg  <= 7'd0;
            mark_row_reg <= 5'd0;
            mark_col_reg <= 7'd0;
            for (int i = 0; i < MAX_LINES; i++) begin
                last_reg[i] <= 8'd0;
            end
            wr_en_reg    <= 1'b0;
            rd_en_reg    <= 1'b0;
            idx_reg      <= '0;
            p_valid_reg  <= 1'b0;
            clr_reg      <= '0;
            clr_lin_reg  <= 1'b0;
            cvalid_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            mark_row_reg <= mark_row_next;
            mark_col_reg <= mark_col_next;
            last_reg     <= last_next;
            wr_en_reg    <= wr_en_next;
            rd_en_reg    <= rd_en_next;
            idx_reg      <= idx_next;
            p_valid_reg  <= p_valid_next;
            clr_reg      <= clr_next;
            clr_lin_reg  <= clr_lin_next;
            cvalid_reg   <= cvalid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule
